### rtl/core/pis_pkg.sv
// ----------------------------------------------------------------------------
// Pairwise insertion sorter package
// Shared sizes and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package pis_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int VALUE_W   = 31;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_W    = $clog2(MAX_ITEMS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // take the request, set the insertion point, read the top entry
    logic drop;    // store is full: remember that a value was lost
    logic shift;   // move the entry just read up by one place
    logic place;   // write the new value at the insertion point
    logic emit;    // read the next entry for output
    logic clear;   // set done: empty the store for the next set
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             full;
    logic             empty;
    logic             last;
    logic             gt;
    logic             pos_one;
    logic             emit_last;
    logic [CNT_W-1:0] count;
  } stat_t;

endpackage

### rtl/core/pairwise_insertion_sorter_unit.sv
// ----------------------------------------------------------------------------
// Pairwise insertion sorter unit
// Collects a set of 31-bit unsigned values and returns them in ascending order.
// ----------------------------------------------------------------------------
// Usage. A request is taken at a rising edge where start is high and busy is
// low; it carries one value and a last bit that closes the set. Each value is
// inserted into a store that is kept in ascending order, with equal values
// kept in arrival order. Insertion walks down the store one entry per cycle,
// so a request is quickest when the store is empty or the value is the
// largest held, and slowest when it lands at the bottom of the store.
// The walk is bound by the single read port of the store RAM.
// Once the closing request has been inserted, the unit emits the set, one
// result per cycle on strobe, after the emit state and the registered read:
// sorted_value rising, final_res on the last one, overflow on every result
// if any value of the set was dropped because the store held 64 entries.
// A closing request that meets a full store still ends the set. Busy stays
// high until the last read has been issued; the last result appears in the
// cycle busy falls, so a new request can be taken at once.
// The receiver cannot stall: each result is valid for exactly one cycle.
// A synchronous reset empties the store and clears the overflow record; the
// store contents themselves are not cleared, as only filled entries are read.
// ----------------------------------------------------------------------------
module pairwise_insertion_sorter_unit import pis_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value,
  input  logic               last,
  output logic               strobe,
  output logic [VALUE_W-1:0] sorted_value,
  output logic               final_res,
  output logic               overflow
);

  cmd_t  cmd;
  stat_t status;

  // The controller decides what happens each cycle; the datapath owns all
  // storage, including the store RAM and the result registers.
  pis_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .last   (last),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  pis_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (value),
    .last         (last),
    .status       (status),
    .sorted_value (sorted_value),
    .strobe       (strobe),
    .final_res    (final_res),
    .overflow     (overflow)
  );

`ifndef SYNTHESIS
  // The fill count can never pass the capacity of the store.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    status.count <= CNT_W'(MAX_ITEMS))
    else $error("item count beyond store capacity");

  // Each insertion adds exactly one entry.
  a_place_count: assert property (@(posedge clk) disable iff (rst)
    cmd.place |=> (status.count == $past(status.count) + CNT_W'(1)))
    else $error("insertion did not grow the store by one");

  // Results of a set come back to back until the final one.
  a_emit_burst: assert property (@(posedge clk) disable iff (rst)
    (strobe && !final_res) |=> strobe)
    else $error("gap inside a result burst");

  // The final result ends the burst and leaves the store empty.
  a_final_end: assert property (@(posedge clk) disable iff (rst)
    (strobe && final_res) |-> (!busy && status.count == '0))
    else $error("store not emptied after the final result");
`endif

endmodule

### rtl/core/pis_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module pis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/pis_datapath.sv
// ----------------------------------------------------------------------------
// Pairwise insertion sorter datapath
// Holds the ordered store, the fill count, the insertion point and the
// output index, and drives the result registers.
// ----------------------------------------------------------------------------
module pis_datapath import pis_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [VALUE_W-1:0] value,
  input  logic               last,
  output stat_t              status,
  output logic [VALUE_W-1:0] sorted_value,
  output logic               strobe,
  output logic               final_res,
  output logic               overflow
);

  logic [VALUE_W-1:0] value_q;
  logic               last_q;
  logic [ADDR_W-1:0]  pos;
  logic [ADDR_W-1:0]  idx;
  logic [CNT_W-1:0]   item_count;
  logic               dropped;
  logic               we;
  logic [ADDR_W-1:0]  rd_addr;
  logic [VALUE_W-1:0] wr_data;
  logic [VALUE_W-1:0] rd_data;
  logic [ADDR_W-1:0]  top_addr;

  assign top_addr = item_count[ADDR_W-1:0] - ADDR_W'(1);

  // The read port serves the walk down the store while inserting and the
  // walk up it while emitting.
  always_comb begin
    if (cmd.load) begin
      rd_addr = top_addr;
    end else if (cmd.shift) begin
      rd_addr = pos - ADDR_W'(2);
    end else begin
      rd_addr = idx;
    end
  end

  assign we      = cmd.shift | cmd.place;
  assign wr_data = cmd.shift ? rd_data : value_q;

  pis_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (pos),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_q <= value;
      last_q  <= last;
    end
    if (cmd.load) begin
      pos <= item_count[ADDR_W-1:0];
    end else if (cmd.shift) begin
      pos <= pos - ADDR_W'(1);
    end
    final_res <= status.emit_last;
    overflow  <= dropped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
      dropped    <= 1'b0;
      idx        <= '0;
      strobe     <= 1'b0;
    end else begin
      strobe <= cmd.emit;
      if (cmd.clear) begin
        item_count <= '0;
        dropped    <= 1'b0;
        idx        <= '0;
      end else begin
        if (cmd.place) begin
          item_count <= item_count + CNT_W'(1);
        end
        if (cmd.drop) begin
          dropped <= 1'b1;
        end
        if (cmd.emit) begin
          idx <= idx + ADDR_W'(1);
        end
      end
    end
  end

  assign sorted_value     = rd_data;
  assign status.full      = (item_count == CNT_W'(MAX_ITEMS));
  assign status.empty     = (item_count == '0);
  assign status.last      = last_q;
  assign status.gt        = (rd_data > value_q);
  assign status.pos_one   = (pos == ADDR_W'(1));
  assign status.emit_last = (idx == top_addr);
  assign status.count     = item_count;

endmodule

### rtl/core/pis_ctrl.sv
// ----------------------------------------------------------------------------
// Pairwise insertion sorter controller
// Sequences acceptance, the insertion walk and the emission of a set.
// ----------------------------------------------------------------------------
module pis_ctrl import pis_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  last,
  input  stat_t status,
  output cmd_t  cmd,
  output logic  busy
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SHIFT = 4'b0010,
    ST_PLACE = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (status.full) begin
            cmd.drop   = 1'b1;
            state_next = last ? ST_EMIT : ST_IDLE;
          end else if (status.empty) begin
            state_next = ST_PLACE;
          end else begin
            state_next = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        if (status.gt) begin
          cmd.shift = 1'b1;
          if (status.pos_one) begin
            state_next = ST_PLACE;
          end
        end else begin
          cmd.place  = 1'b1;
          state_next = status.last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_PLACE: begin
        cmd.place  = 1'b1;
        state_next = status.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_last) begin
          cmd.clear  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule
